[hdl/jhau_pkg.sv]
`timescale 1ns / 1ps
// Package with the constants, types and fixed-point helpers of the joint hierarchy update unit.
package jhau_pkg;

    localparam int MAX_JOINTS = 64;
    localparam int ENTRY_BITS = 16;
    localparam int FRAC_BITS  = 12;

    localparam int JOINT_W   = 6;
    localparam int ROW_W     = 64;
    localparam int LANE_BITS = 16;
    localparam int LANES     = 4;
    localparam int ROWS      = 3;
    localparam int ADDR_W    = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
    localparam int PROD_W    = 2 * ENTRY_BITS;
    localparam int SUM_W     = 2 * ENTRY_BITS + 2;

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'((64'sd1 <<< (ENTRY_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX - SUM_W'(1);

    typedef logic [ROW_W-1:0] row_t;
    typedef logic [ROWS-1:0][ROW_W-1:0] mat_t;
    typedef logic signed [ENTRY_BITS-1:0] entry_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    function automatic entry_t lane_get(input row_t row, input int c);
        return entry_t'(row[LANE_BITS*c +: ENTRY_BITS]);
    endfunction

    function automatic logic [LANE_BITS-1:0] lane_put(input entry_t v);
        return LANE_BITS'(v);
    endfunction

    function automatic sum_t mul_trunc(input entry_t a, input entry_t b);
        logic signed [PROD_W-1:0] p;
        p = a * b;
        return SUM_W'(p >>> FRAC_BITS);
    endfunction

    function automatic entry_t saturate(input sum_t v);
        entry_t res;
        if (v > SUM_MAX)
        begin
            res = SUM_MAX[ENTRY_BITS-1:0];
        end
        else if (v < SUM_MIN)
        begin
            res = SUM_MIN[ENTRY_BITS-1:0];
        end
        else
        begin
            res = v[ENTRY_BITS-1:0];
        end
        return res;
    endfunction

endpackage

[hdl/jhau_in_if.sv]
`timescale 1ns / 1ps
// Input channel interface carrying one joint word with its local transform.
interface jhau_in_if
    import jhau_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [JOINT_W-1:0] joint_index;
    logic [JOINT_W-1:0] parent_index;
    logic [ROW_W-1:0]   local_row0;
    logic [ROW_W-1:0]   local_row1;
    logic [ROW_W-1:0]   local_row2;

    modport source (output valid, output joint_index, output parent_index,
                    output local_row0, output local_row1, output local_row2,
                    input ready);
    modport sink (input valid, input joint_index, input parent_index,
                  input local_row0, input local_row1, input local_row2,
                  output ready);
endinterface

[hdl/jhau_out_if.sv]
`timescale 1ns / 1ps
// Output channel interface carrying one joint word with its absolute transform.
interface jhau_out_if
    import jhau_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [JOINT_W-1:0] result_joint;
    logic [ROW_W-1:0]   abs_row0;
    logic [ROW_W-1:0]   abs_row1;
    logic [ROW_W-1:0]   abs_row2;
    logic               bad_parent;

    modport source (output valid, output result_joint, output abs_row0, output abs_row1,
                    output abs_row2, output bad_parent, input ready);
    modport sink (input valid, input result_joint, input abs_row0, input abs_row1,
                  input abs_row2, input bad_parent, output ready);
endinterface

[hdl/joint_hierarchy_affine_update_unit.sv]
`timescale 1ns / 1ps
// Top level of the joint hierarchy affine update unit.
// The unit takes one joint word per clock cycle and presents its absolute transform in
// the output register: the edge that accepts the word also reads the parent's entry from
// the transform memory, and the edge on which stage one advances registers the composed
// result and writes it back. A result that waits on the output holds the word behind it,
// and the input stalls only while both are held. When a joint names as its parent the
// joint directly ahead of it, the parent transform is taken from the result register
// instead of the memory, so a chain of joints streams at full rate. The memory holds one
// entry per joint and needs no clearing after reset; a parent entry must be written
// before it is used.
module joint_hierarchy_affine_update_unit
    import jhau_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    jhau_in_if.sink  joint_in,
    jhau_out_if.source joint_out
);

    mat_t abs_mem [MAX_JOINTS];

    logic               s1_valid_reg;
    logic [JOINT_W-1:0] s1_joint_reg;
    logic [JOINT_W-1:0] s1_parent_reg;
    mat_t               s1_local_reg;
    mat_t               s1_rd_reg;
    logic               s1_bypass_reg;
    logic               s1_par_oor_reg;

    logic               out_valid_reg;
    logic [JOINT_W-1:0] out_joint_reg;
    mat_t               out_rows_reg;
    logic               out_bad_reg;

    logic               s1_adv;
    logic               in_take;
    logic               s1_store;
    logic               in_par_oor;
    mat_t               par_rows;
    mat_t               res_next;
    logic               bad_next;
    logic               pass;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || joint_out.ready);
    assign in_take  = joint_in.valid && joint_in.ready;
    assign s1_store = s1_adv && (32'(s1_joint_reg) < MAX_JOINTS);
    assign in_par_oor = !(32'(joint_in.parent_index) < MAX_JOINTS);

    assign joint_in.ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        sum_t   acc;
        entry_t p_ent;
        entry_t l_ent;
        logic [LANE_BITS-1:0] lane;

        pass = (s1_joint_reg == '0) || (s1_parent_reg >= s1_joint_reg);
        bad_next = (s1_joint_reg != '0) && (s1_parent_reg >= s1_joint_reg);

        if (s1_bypass_reg)
        begin
            par_rows = out_rows_reg;
        end
        else if (s1_par_oor_reg)
        begin
            par_rows = '0;
        end
        else
        begin
            par_rows = s1_rd_reg;
        end

        res_next = '0;
        for (int r = 0; r < ROWS; r++)
        begin
            for (int c = 0; c < LANES; c++)
            begin
                acc = '0;
                for (int k = 0; k < ROWS; k++)
                begin
                    p_ent = lane_get(par_rows[r], k);
                    l_ent = lane_get(s1_local_reg[k], c);
                    acc = acc + mul_trunc(p_ent, l_ent);
                end
                if (c == LANES - 1)
                begin
                    acc = acc + SUM_W'(lane_get(par_rows[r], LANES - 1));
                end
                if (pass)
                begin
                    lane = lane_put(lane_get(s1_local_reg[r], c));
                end
                else
                begin
                    lane = lane_put(saturate(acc));
                end
                res_next[r][LANE_BITS*c +: LANE_BITS] = lane;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (joint_in.ready)
            begin
                s1_valid_reg <= joint_in.valid;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (joint_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_joint_reg   <= joint_in.joint_index;
            s1_parent_reg  <= joint_in.parent_index;
            s1_local_reg   <= {joint_in.local_row2, joint_in.local_row1, joint_in.local_row0};
            s1_par_oor_reg <= in_par_oor;
            s1_bypass_reg  <= s1_store && (joint_in.parent_index == s1_joint_reg);
            if (!in_par_oor)
            begin
                s1_rd_reg <= abs_mem[ADDR_W'(joint_in.parent_index)];
            end
        end
        if (s1_store)
        begin
            abs_mem[ADDR_W'(s1_joint_reg)] <= res_next;
        end
        if (s1_adv)
        begin
            out_joint_reg <= s1_joint_reg;
            out_rows_reg  <= res_next;
            out_bad_reg   <= bad_next;
        end
    end

    assign joint_out.valid        = out_valid_reg;
    assign joint_out.result_joint = out_joint_reg;
    assign joint_out.abs_row0     = out_rows_reg[0];
    assign joint_out.abs_row1     = out_rows_reg[1];
    assign joint_out.abs_row2     = out_rows_reg[2];
    assign joint_out.bad_parent   = out_bad_reg;

endmodule
